// File: rtl/ofsd_pkg.sv
`timescale 1ns / 1ps

package ofsd_pkg;

   // Frame geometry
   localparam int FRAME_LENGTH = 14;
   localparam int COUNT_WIDTH  = $clog2(FRAME_LENGTH);

   // Sync sequence bytes
   localparam logic [7:0] SYNC_BYTE_0 = 8'h55;
   localparam logic [7:0] SYNC_BYTE_1 = 8'haa;
   localparam logic [7:0] SYNC_BYTE_2 = 8'h56;
   localparam logic [7:0] SYNC_BYTE_3 = 8'haa;

   // Sync hunt state codes
   localparam logic [2:0] SYNC_WAIT      = 3'd0;
   localparam logic [2:0] SYNC_GOT55     = 3'd1;
   localparam logic [2:0] SYNC_GOT55AA   = 3'd2;
   localparam logic [2:0] SYNC_GOT55AA56 = 3'd3;
   localparam logic [2:0] SYNC_COLLECT   = 3'd4;

   // Control register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_LIMIT      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_LIMIT       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH_LIMIT      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_LOW        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_HIGH       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WANTED_SIGNATURE = 3'd5;

   // Register reset values
   localparam logic [15:0]        RIGHT_LIMIT_RESET      = 16'd200;
   localparam logic [15:0]        LEFT_LIMIT_RESET       = 16'd100;
   localparam logic [15:0]        WIDTH_LIMIT_RESET      = 16'd56;
   localparam logic signed [15:0] ANGLE_LOW_RESET        = 16'sd70;
   localparam logic signed [15:0] ANGLE_HIGH_RESET       = 16'sd110;
   localparam logic [15:0]        WANTED_SIGNATURE_RESET = 16'd10;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [15:0]        right_limit;
      logic [15:0]        left_limit;
      logic [15:0]        width_limit;
      logic signed [15:0] angle_low;
      logic signed [15:0] angle_high;
      logic [15:0]        wanted_signature;
   } cfg_type;

   // Decoded words of one complete frame
   typedef struct packed {
      logic [15:0]        signature;
      logic [15:0]        x_centre;
      logic [15:0]        obj_width;
      logic signed [15:0] angle;
   } frame_type;

endpackage

// File: rtl/ofsd_channels.sv
`timescale 1ns / 1ps

// Received byte channel
interface ofsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Motor command channel
interface ofsd_rsp_if;
   logic valid;
   logic ready;
   logic left_forward;
   logic left_backward;
   logic right_forward;
   logic right_backward;
   logic fall_alert;
   modport source (output valid, output left_forward, output left_backward,
                   output right_forward, output right_backward, output fall_alert,
                   input ready);
   modport sink (input valid, input left_forward, input left_backward,
                 input right_forward, input right_backward, input fall_alert,
                 output ready);
endinterface

// Control register write channel
interface ofsd_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ofsd_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [15:0]                          data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/ofsd_csr.sv
`timescale 1ns / 1ps

module ofsd_csr (
   input  logic              clock,
   input  logic              reset,
   ofsd_csr_if.sink          csr_bus,
   output ofsd_pkg::cfg_type cfg
);
   import ofsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   // Always ready: every write is taken and registered straight into cfg_ff
   assign csr_bus.ready = 1'b1;
   assign write_en      = csr_bus.valid;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_bus.index)
            CSR_RIGHT_LIMIT:      cfg_in.right_limit      = csr_bus.data;
            CSR_LEFT_LIMIT:       cfg_in.left_limit       = csr_bus.data;
            CSR_WIDTH_LIMIT:      cfg_in.width_limit      = csr_bus.data;
            CSR_ANGLE_LOW:        cfg_in.angle_low        = csr_bus.data;
            CSR_ANGLE_HIGH:       cfg_in.angle_high       = csr_bus.data;
            CSR_WANTED_SIGNATURE: cfg_in.wanted_signature = csr_bus.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_limit      <= RIGHT_LIMIT_RESET;
         cfg_ff.left_limit       <= LEFT_LIMIT_RESET;
         cfg_ff.width_limit      <= WIDTH_LIMIT_RESET;
         cfg_ff.angle_low        <= ANGLE_LOW_RESET;
         cfg_ff.angle_high       <= ANGLE_HIGH_RESET;
         cfg_ff.wanted_signature <= WANTED_SIGNATURE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ofsd_framer.sv
`timescale 1ns / 1ps

module ofsd_framer (
   input  logic                clock,
   input  logic                reset,
   ofsd_req_if.sink            req_bus,
   output logic                frame_valid,
   output ofsd_pkg::frame_type frame,
   input  logic                frame_ready
);
   import ofsd_pkg::*;

   logic [2:0]  sync_state_ff;
   logic [2:0]  sync_state_in;
   count_type   count_ff;
   count_type   count_in;
   count_type   wr_index;
   logic [7:0]  frame_bytes_ff [FRAME_LENGTH];
   logic        frame_valid_ff;
   logic        frame_valid_in;
   frame_type   frame_ff;
   logic        accept;
   logic        collecting;
   logic        last_byte;
   logic [7:0]  rx;

   // Take a byte whenever the frame register is free or drains this cycle
   assign req_bus.ready = !frame_valid_ff || frame_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rx            = req_bus.rx_byte;

   // Wrap an out-of-range count back to the first slot
   assign wr_index   = (count_ff >= COUNT_WIDTH'(FRAME_LENGTH)) ? '0 : count_ff;
   assign collecting = (sync_state_ff == SYNC_COLLECT);
   assign last_byte  = collecting && (wr_index == COUNT_WIDTH'(FRAME_LENGTH - 1));

   // Sync hunt; a mismatching byte is not rechecked as a first sync byte
   always_comb begin
      sync_state_in = sync_state_ff;
      count_in      = count_ff;
      if (accept) begin
         unique case (sync_state_ff)
            SYNC_GOT55:
               sync_state_in = (rx == SYNC_BYTE_1) ? SYNC_GOT55AA : SYNC_WAIT;
            SYNC_GOT55AA:
               sync_state_in = (rx == SYNC_BYTE_2) ? SYNC_GOT55AA56 : SYNC_WAIT;
            SYNC_GOT55AA56:
               sync_state_in = (rx == SYNC_BYTE_3) ? SYNC_COLLECT : SYNC_WAIT;
            SYNC_COLLECT: begin
               if (last_byte) begin
                  sync_state_in = SYNC_WAIT;
                  count_in      = '0;
               end else begin
                  count_in = wr_index + 1'b1;
               end
            end
            default:
               sync_state_in = (rx == SYNC_BYTE_0) ? SYNC_GOT55 : SYNC_WAIT;
         endcase
      end
   end

   // Hold a completed frame until the steering stage takes it
   always_comb begin
      if (accept && last_byte) begin
         frame_valid_in = 1'b1;
      end else if (frame_ready) begin
         frame_valid_in = 1'b0;
      end else begin
         frame_valid_in = frame_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_state_ff  <= SYNC_WAIT;
         count_ff       <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         sync_state_ff  <= sync_state_in;
         count_ff       <= count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   // Store frame bytes; the last byte goes straight into the frame register
   always_ff @(posedge clock) begin
      if (accept && collecting) begin
         frame_bytes_ff[wr_index] <= rx;
      end
      if (accept && last_byte) begin
         frame_ff.signature <= {frame_bytes_ff[3], frame_bytes_ff[2]};
         frame_ff.x_centre  <= {frame_bytes_ff[5], frame_bytes_ff[4]};
         frame_ff.obj_width <= {frame_bytes_ff[9], frame_bytes_ff[8]};
         frame_ff.angle     <= {rx, frame_bytes_ff[12]};
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

   // A finished frame always restarts the sync hunt
   a_frame_restarts_sync: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (sync_state_ff == SYNC_WAIT && count_ff == '0))
      else $error("sync hunt not restarted after a frame");

   // The count only advances while collecting
   a_count_idle_outside_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && !collecting) |=> $stable(count_ff))
      else $error("byte count moved outside a frame");

endmodule

// File: rtl/ofsd_steer.sv
`timescale 1ns / 1ps

module ofsd_steer (
   input  logic                clock,
   input  logic                reset,
   input  ofsd_pkg::cfg_type   cfg,
   input  logic                frame_valid,
   input  ofsd_pkg::frame_type frame,
   output logic                frame_ready,
   ofsd_rsp_if.source          rsp_bus
);
   import ofsd_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [3:0] motor_ff;
   logic [3:0] motor_in;
   logic       fall_ff;
   logic       fall_in;
   logic       sig_match;
   logic       load;

   // Output register frees up when empty or taken this cycle
   assign frame_ready = !rsp_valid_ff || rsp_bus.ready;
   assign load        = frame_valid && frame_ready;
   assign sig_match   = (frame.signature == cfg.wanted_signature);

   // Pick motor levels: right, then left, then forward, else stop
   always_comb begin
      priority if (frame.x_centre > cfg.right_limit) begin
         motor_in = 4'b0110;
      end else if (frame.x_centre < cfg.left_limit) begin
         motor_in = 4'b1001;
      end else if (frame.obj_width < cfg.width_limit) begin
         motor_in = 4'b1010;
      end else begin
         motor_in = 4'b0000;
      end
   end

   assign fall_in = (frame.angle > cfg.angle_low) && (frame.angle < cfg.angle_high);

   // Drop frames whose signature does not match
   always_comb begin
      if (load) begin
         rsp_valid_in = sig_match;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         motor_ff <= motor_in;
         fall_ff  <= fall_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.left_forward   = motor_ff[3];
   assign rsp_bus.left_backward  = motor_ff[2];
   assign rsp_bus.right_forward  = motor_ff[1];
   assign rsp_bus.right_backward = motor_ff[0];
   assign rsp_bus.fall_alert     = fall_ff;

   // Never drive one motor both ways
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(motor_ff[3] && motor_ff[2]) && !(motor_ff[1] && motor_ff[0]))
      else $error("motor driven forward and backward at once");

   // A mismatching frame produces no transaction
   a_mismatch_dropped: assert property (@(posedge clock) disable iff (reset)
      (load && !sig_match) |=> !rsp_valid_ff)
      else $error("frame with foreign signature was emitted");

endmodule

// File: rtl/object_frame_steering_decoder_core.sv
`timescale 1ns / 1ps
// A frame's last byte goes straight into the framer's frame register, then into the
// steering output register that drives rsp.
// Throughput: one received byte per cycle unless stalled; the framer and the steering
// stage each hold one registered transaction and advance together under backpressure.
// Reset (synchronous, active high): sync hunt restarts, pipeline empties,
// control registers return to their defaults; stored frame bytes are kept.
module object_frame_steering_decoder_core (
   input  logic      clock,
   input  logic      reset,
   ofsd_req_if.sink  req_bus,
   ofsd_rsp_if.source rsp_bus,
   ofsd_csr_if.sink  csr_bus
);
   import ofsd_pkg::*;

   cfg_type   cfg;
   frame_type frame;
   logic      frame_valid;
   logic      frame_ready;

   ofsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ofsd_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready)
   );

   ofsd_steer u_steer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ofsd_pkg::*;

   // One decoded steering decision, MSB first as the fields appear on rsp_bus
   typedef struct packed {
      logic left_forward;
      logic left_backward;
      logic right_forward;
      logic right_backward;
      logic fall_alert;
   } motor_cmd_type;

   localparam int FRAME_WORDS = FRAME_LENGTH / 2;

   logic clock = 1'b0;
   logic reset;

   ofsd_req_if req_bus ();
   ofsd_rsp_if rsp_bus ();
   ofsd_csr_if csr_bus ();

   object_frame_steering_decoder_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Steering predictor state
   logic [2:0]  hunt_state;
   count_type   collect_count;
   logic [7:0]  frame_buf [FRAME_LENGTH];
   cfg_type     steer_cfg;

   motor_cmd_type pending_cmds [$];
   int unsigned mismatch_count;
   int unsigned frame_bytes_sent;

   // Sender and receiver pacing
   int unsigned tx_mode;
   int unsigned tx_burst_left;
   int unsigned rx_mode;
   int unsigned rx_run_left;
   int unsigned rx_hold_cycles;
   logic        rx_level;

   string cmd_field_names [5] = '{"fall_alert", "right_backward", "right_forward",
                                  "left_backward", "left_forward"};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard limit on the run
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t: mismatch: %s", $time, msg);
   endtask

   function automatic logic [7:0] sync_byte(input int unsigned pos);
      case (pos)
         0: return SYNC_BYTE_0;
         1: return SYNC_BYTE_1;
         2: return SYNC_BYTE_2;
         default: return SYNC_BYTE_3;
      endcase
   endfunction

   // Advance the sync hunt by one byte; return 1 when a frame yields a command
   function automatic bit decode_rx_byte(input logic [7:0] b, output motor_cmd_type cmd);
      frame_type fr;
      cmd = '0;
      case (hunt_state)
         SYNC_GOT55: begin
            hunt_state = (b == SYNC_BYTE_1) ? SYNC_GOT55AA : SYNC_WAIT;
            return 1'b0;
         end
         SYNC_GOT55AA: begin
            hunt_state = (b == SYNC_BYTE_2) ? SYNC_GOT55AA56 : SYNC_WAIT;
            return 1'b0;
         end
         SYNC_GOT55AA56: begin
            hunt_state = (b == SYNC_BYTE_3) ? SYNC_COLLECT : SYNC_WAIT;
            return 1'b0;
         end
         SYNC_COLLECT: begin
         end
         default: begin
            hunt_state = (b == SYNC_BYTE_0) ? SYNC_GOT55 : SYNC_WAIT;
            return 1'b0;
         end
      endcase

      frame_buf[collect_count] = b;
      collect_count++;
      if (collect_count < FRAME_LENGTH)
         return 1'b0;
      hunt_state    = SYNC_WAIT;
      collect_count = '0;

      // Words are little-endian; checksum is ignored
      fr.signature = {frame_buf[3], frame_buf[2]};
      fr.x_centre  = {frame_buf[5], frame_buf[4]};
      fr.obj_width = {frame_buf[9], frame_buf[8]};
      fr.angle     = {frame_buf[13], frame_buf[12]};
      if (fr.signature != steer_cfg.wanted_signature)
         return 1'b0;

      cmd.fall_alert = ($signed(fr.angle) > $signed(steer_cfg.angle_low)) &&
                       ($signed(fr.angle) < $signed(steer_cfg.angle_high));
      if (fr.x_centre > steer_cfg.right_limit) begin
         cmd.left_backward = 1'b1;
         cmd.right_forward = 1'b1;
      end else if (fr.x_centre < steer_cfg.left_limit) begin
         cmd.left_forward   = 1'b1;
         cmd.right_backward = 1'b1;
      end else if (fr.obj_width < steer_cfg.width_limit) begin
         cmd.left_forward  = 1'b1;
         cmd.right_forward = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_near(input logic [15:0] pivot);
      case ($urandom_range(0, 5))
         0: return pivot - 16'd1;
         1: return pivot;
         2: return pivot + 16'd1;
         3: return 16'h0000;
         4: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one byte; hold valid high afterwards so back-to-back bytes stay high
   task automatic send_rx_byte(input logic [7:0] b);
      motor_cmd_type cmd;
      int unsigned gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(1, 40);
         gap = (tx_mode == 0) ? 0 : $urandom_range(1, (tx_mode == 1) ? 3 : 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      tx_burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (decode_rx_byte(b, cmd))
         pending_cmds.push_back(cmd);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [15:0] cks, sig, xc, yc, wd, ht, ang);
      logic [15:0] words [FRAME_WORDS];
      words = '{cks, sig, xc, yc, wd, ht, ang};
      for (int i = 0; i < 4; i++)
         send_rx_byte(sync_byte(i));
      for (int i = 0; i < FRAME_WORDS; i++) begin
         send_rx_byte(words[i][7:0]);
         send_rx_byte(words[i][15:8]);
      end
      frame_bytes_sent += 4 + FRAME_LENGTH;
   endtask

   // Frame with fields clustered around the current limits
   task automatic send_random_frame(input bit match_sig);
      logic [15:0] sig;
      logic [15:0] xc;
      logic [15:0] wd;
      logic [15:0] ang;
      case ($urandom_range(0, 3))
         0: xc = pick_near(steer_cfg.right_limit);
         1: xc = pick_near(steer_cfg.left_limit);
         2: xc = steer_cfg.left_limit +
                 ((steer_cfg.right_limit - steer_cfg.left_limit) >> 1);
         default: xc = 16'($urandom);
      endcase
      wd = ($urandom_range(0, 2) != 0) ? pick_near(steer_cfg.width_limit)
                                       : 16'($urandom);
      case ($urandom_range(0, 4))
         0: ang = pick_near(steer_cfg.angle_low);
         1: ang = pick_near(steer_cfg.angle_high);
         2: ang = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         3: ang = steer_cfg.angle_low +
                  ((steer_cfg.angle_high - steer_cfg.angle_low) >> 1);
         default: ang = 16'($urandom);
      endcase
      sig = steer_cfg.wanted_signature;
      if (!match_sig)
         sig = sig ^ 16'($urandom_range(1, 16'hffff));
      send_frame(16'($urandom), sig, xc, 16'($urandom), wd, 16'($urandom), ang);
   endtask

   // Mostly good frames, some foreign signatures, noise and broken sync
   task automatic run_traffic(input int unsigned n_bytes);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned depth;
      logic [7:0]  bad;
      stop_at = frame_bytes_sent + n_bytes;
      while (frame_bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            send_random_frame(1'b1);
         end else if (pick < 82) begin
            send_random_frame(1'b0);
         end else if (pick < 91) begin
            repeat ($urandom_range(1, 4))
               send_rx_byte($urandom_range(0, 3) == 0 ? SYNC_BYTE_0 : 8'($urandom));
         end else begin
            depth = $urandom_range(1, 3);
            for (int i = 0; i < depth; i++)
               send_rx_byte(sync_byte(i));
            bad = $urandom_range(0, 1) ? SYNC_BYTE_0 : 8'($urandom);
            if (bad == sync_byte(depth))
               bad = bad ^ 8'h01;
            send_rx_byte(bad);
         end
      end
   endtask

   // Drop valid and let the pipeline drain completely
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_RIGHT_LIMIT:      steer_cfg.right_limit      = val;
         CSR_LEFT_LIMIT:       steer_cfg.left_limit       = val;
         CSR_WIDTH_LIMIT:      steer_cfg.width_limit      = val;
         CSR_ANGLE_LOW:        steer_cfg.angle_low        = val;
         CSR_ANGLE_HIGH:       steer_cfg.angle_high       = val;
         CSR_WANTED_SIGNATURE: steer_cfg.wanted_signature = val;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Write every register, then poke an unmapped index that must be ignored
   task automatic apply_config(input cfg_type c);
      wait_idle();
      csr_write(CSR_RIGHT_LIMIT, c.right_limit);
      csr_write(CSR_LEFT_LIMIT, c.left_limit);
      csr_write(CSR_WIDTH_LIMIT, c.width_limit);
      csr_write(CSR_ANGLE_LOW, c.angle_low);
      csr_write(CSR_ANGLE_HIGH, c.angle_high);
      csr_write(CSR_WANTED_SIGNATURE, c.wanted_signature);
      csr_write(CSR_WANTED_SIGNATURE + CSR_INDEX_WIDTH'($urandom_range(1, 2)),
                16'($urandom));
   endtask

   // Broken and overlapping sync, then one frame with extreme field values
   task automatic test_sync_hunt();
      tx_mode = 0;
      rx_mode = 0;
      send_rx_byte(SYNC_BYTE_0);
      send_rx_byte(SYNC_BYTE_0);
      send_rx_byte(SYNC_BYTE_1);
      send_rx_byte(SYNC_BYTE_2);
      send_rx_byte(SYNC_BYTE_3);
      send_frame(16'hffff, WANTED_SIGNATURE_RESET, 16'hffff, 16'h0000, 16'h0000,
                 16'hff00, 16'd90);
   endtask

   task automatic test_reset_defaults();
      tx_mode = 1;
      rx_mode = 1;
      run_traffic(150);
   endtask

   task automatic test_config_extremes();
      cfg_type c;
      c.right_limit      = 16'hffff;
      c.left_limit       = 16'h0000;
      c.width_limit      = 16'hffff;
      c.angle_low        = 16'h8000;
      c.angle_high       = 16'h7fff;
      c.wanted_signature = 16'hffff;
      apply_config(c);
      tx_mode = 0;
      rx_mode = 0;
      run_traffic(200);

      c.right_limit      = 16'h0000;
      c.left_limit       = 16'hffff;
      c.width_limit      = 16'h0000;
      c.angle_low        = 16'h7fff;
      c.angle_high       = 16'h8000;
      c.wanted_signature = 16'h0000;
      apply_config(c);
      tx_mode = 2;
      rx_mode = 2;
      run_traffic(200);
   endtask

   // Left limit above right limit: turn right must still win
   task automatic test_inverted_limits();
      cfg_type c;
      c.right_limit      = 16'($urandom_range(0, 30000));
      c.left_limit       = c.right_limit + 16'($urandom_range(1, 30000));
      c.width_limit      = 16'($urandom);
      c.angle_low        = 16'($urandom_range(100, 20000));
      c.angle_high       = 16'($urandom_range(0, 99));
      c.wanted_signature = 16'($urandom);
      apply_config(c);
      tx_mode = 1;
      rx_mode = 2;
      run_traffic(200);
   endtask

   task automatic test_random_config();
      cfg_type c;
      repeat (3) begin
         c = cfg_type'({$urandom, $urandom, $urandom});
         apply_config(c);
         tx_mode = $urandom_range(0, 2);
         rx_mode = $urandom_range(0, 2);
         run_traffic(170);
      end
   endtask

   // Stall the result side for a long stretch while frames keep coming
   task automatic test_backpressure();
      wait_idle();
      tx_mode = 0;
      rx_mode = 1;
      rx_hold_cycles = 400;
      repeat (10) send_random_frame(1'b1);
   endtask

   task automatic finish_run();
      int unsigned waited;
      req_bus.valid <= 1'b0;
      rx_mode = 0;
      waited = 0;
      while (pending_cmds.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (pending_cmds.size() != 0)
         report_mismatch($sformatf("%0d motor commands never arrived",
                                   pending_cmds.size()));
   endtask

   // Result side stall pattern, with an optional long hold-off
   always @(negedge clock) begin
      if (rx_hold_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold_cycles--;
      end else begin
         if (rx_run_left == 0) begin
            rx_level    = (rx_mode == 0) ? 1'b1 : ~rx_level;
            rx_run_left = rx_level ? $urandom_range(1, 12)
                                   : $urandom_range(1, (rx_mode == 1) ? 3 : 10);
         end
         rx_run_left--;
         rsp_bus.ready <= rx_level;
      end
   end

   // Compare each accepted motor command with the oldest prediction
   always @(posedge clock) begin : check_motor_cmds
      motor_cmd_type got_cmd;
      motor_cmd_type want_cmd;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got_cmd = {rsp_bus.left_forward, rsp_bus.left_backward, rsp_bus.right_forward,
                    rsp_bus.right_backward, rsp_bus.fall_alert};
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected motor command %b", got_cmd));
         end else begin
            want_cmd = pending_cmds.pop_front();
            for (int i = 0; i < $bits(motor_cmd_type); i++)
               if (got_cmd[i] !== want_cmd[i])
                  report_mismatch($sformatf("%s got %b expected %b",
                                            cmd_field_names[i], got_cmd[i], want_cmd[i]));
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;

      hunt_state    = SYNC_WAIT;
      collect_count = '0;
      for (int i = 0; i < FRAME_LENGTH; i++)
         frame_buf[i] = '0;
      steer_cfg.right_limit      = RIGHT_LIMIT_RESET;
      steer_cfg.left_limit       = LEFT_LIMIT_RESET;
      steer_cfg.width_limit      = WIDTH_LIMIT_RESET;
      steer_cfg.angle_low        = ANGLE_LOW_RESET;
      steer_cfg.angle_high       = ANGLE_HIGH_RESET;
      steer_cfg.wanted_signature = WANTED_SIGNATURE_RESET;

      mismatch_count   = 0;
      frame_bytes_sent = 0;
      tx_mode          = 0;
      tx_burst_left    = 0;
      rx_mode          = 0;
      rx_run_left      = 0;
      rx_hold_cycles   = 0;
      rx_level         = 1'b1;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_sync_hunt();
      test_reset_defaults();
      test_config_extremes();
      test_inverted_limits();
      test_random_config();
      test_backpressure();
      finish_run();

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
